### design/ats_pkg.sv
// ----------------------------------------------------------------------------
// ats_pkg: shared types and constants of the annealing 2-opt step block
// Beat layouts, function and register codes, generator and exp constants,
// and the constant table of 2^(-k/2^EXP_TABLE_BITS) in Q.32.
// ----------------------------------------------------------------------------
package ats_pkg;

    localparam int MAX_CITIES     = 64;
    localparam int POS_W          = 6;
    localparam int CNT_W          = 7;
    localparam int DIST_BITS      = 24;
    localparam int DIST_AW        = 2 * POS_W;
    localparam int PAIR_DEPTH     = (MAX_CITIES * MAX_CITIES) / 2;
    localparam int PAIR_AW        = $clog2(PAIR_DEPTH);
    localparam int DELTA_W        = DIST_BITS + 3;
    localparam int EXP_TABLE_BITS = 8;
    localparam int EXP_SIZE       = 1 << EXP_TABLE_BITS;

    localparam logic [31:0] LCG_MUL_LO = 32'hDEEC_E66D;
    localparam logic [31:0] LCG_MUL_HI = 32'd5;
    localparam logic [63:0] LCG_ADD    = 64'd11;
    localparam logic [31:0] LOG2E_Q30  = 32'd1549082005;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_STEP  = 2'd1,
        FUNC_START = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    typedef enum logic {
        CFG_CITY_COUNT = 1'b0,
        CFG_SEED       = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [3:0]           pad;
        logic [POS_W-1:0]     position;
        logic [31:0]          inverse_temperature;
        logic [DIST_BITS-1:0] distance;
        logic [POS_W-1:0]     col;
        logic [POS_W-1:0]     row;
        func_t                func;
    } in_beat_t;

    typedef struct packed {
        logic [4:0]       pad;
        logic [POS_W-1:0] city;
        logic [POS_W-1:0] last_pos;
        logic [POS_W-1:0] first_pos;
        logic [31:0]      tour_length;
        logic             accepted;
    } out_beat_t;

    typedef struct packed {
        logic [POS_W-1:0] last;
        logic [POS_W-1:0] first;
    } pair_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bval;
        int s;
        v    = v_in;
        res  = 64'd0;
        bval = 64'd1 << 62;
        for (s = 0; s < 32; s++) begin
            if (bval > v) bval = bval >> 2;
        end
        for (s = 0; s < 32; s++) begin
            if (bval != 64'd0) begin
                if (v >= res + bval) begin
                    v   = v - (res + bval);
                    res = (res >> 1) + bval;
                end else begin
                    res = res >> 1;
                end
                bval = bval >> 2;
            end
        end
        return res;
    endfunction

    function automatic logic [EXP_SIZE-1:0][32:0] build_exp();
        logic [EXP_SIZE-1:0][32:0] tab;
        logic [63:0] r;
        logic [63:0] prev;
        logic [63:0] prod;
        int k;
        r = 64'd1 << 31;
        for (k = 0; k < EXP_TABLE_BITS; k++) r = isqrt64(r << 32);
        tab[0] = 33'h1_0000_0000;
        prev   = 64'h1_0000_0000;
        for (k = 1; k < EXP_SIZE; k++) begin
            prod   = prev * r + (64'd1 << 31);
            prev   = prod >> 32;
            tab[k] = prev[32:0];
        end
        return tab;
    endfunction

    localparam logic [EXP_SIZE-1:0][32:0] EXP_TAB = build_exp();

endpackage

### design/ats_ram.sv
// ----------------------------------------------------------------------------
// ats_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ats_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/ats_mul.sv
// ----------------------------------------------------------------------------
// ats_mul: shared registered multiplier
// Full product of two unsigned operands, registered and available in the next cycle.
// ----------------------------------------------------------------------------
module ats_mul #(
    parameter int A_W = 32,
    parameter int B_W = 32
) (
    input  logic               aclk,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] p
);

    logic [A_W+B_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
    end

    assign p = p_reg;

endmodule

### design/ats_div.sv
// ----------------------------------------------------------------------------
// ats_div: bit-serial remainder unit
// Restoring division, one dividend bit per cycle; the remainder is held after done.
// ----------------------------------------------------------------------------
module ats_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 11
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [DEN_W-1:0] rem
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                num_reg  <= dividend;
                den_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= CW'(NUM_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                // Shift one bit in and subtract when the divisor fits.
                if (trial >= {1'b0, den_reg}) begin
                    rem_reg <= diff[DEN_W-1:0];
                end else begin
                    rem_reg <= trial[DEN_W-1:0];
                end
                num_reg <= num_reg << 1;
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

### design/anneal_two_opt_step.sv
// ----------------------------------------------------------------------------
// anneal_two_opt_step: simulated-annealing 2-opt move over a stored tour
// A step draws a pair index, prices the move and reverses the segment on accept.
// Start builds the pair list and then sums the length of the identity tour.
// One beat at a time: no new beat is taken until the result beat is issued.
// Reset: synchronous, active low; tour reads as identity via per-entry valid bits.
// ----------------------------------------------------------------------------
module anneal_two_opt_step (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [63:0] cfg_wdata,
    // Input beat: func, row, col, distance, inverse_temperature, position.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,
    // Result beat: accepted, tour_length, first_pos, last_pos, city.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata
);

    localparam int PW = ats_pkg::POS_W;
    localparam int NW = ats_pkg::CNT_W;
    localparam int DW = ats_pkg::DIST_BITS;
    localparam int XW = ats_pkg::DELTA_W;
    localparam int EB = ats_pkg::EXP_TABLE_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_RDPOS, S_CITY, S_PAIR, S_SUMA, S_SUMB,
        S_DRAW0, S_DRAW1, S_DRAW2, S_DRAW3, S_DIV, S_PAIRRD, S_PAIRGET,
        S_TOUR, S_DIST, S_DEC, S_MULX, S_MULY, S_MULW, S_CMP, S_ACC,
        S_RV0, S_RV1, S_RV2, S_RV3, S_FIN
    } state_t;

    ats_pkg::in_beat_t  in_beat;
    ats_pkg::out_beat_t out_beat;

    state_t                     state_reg;
    logic [2:0]                 cnt_reg;
    logic                       test_reg;
    logic [PW-1:0]              row_reg, col_reg, pos_reg;
    logic [DW-1:0]              dist_reg;
    logic [31:0]                invt_reg;
    logic [NW-1:0]              city_count_reg;
    logic [63:0]                g_reg;
    logic [63:0]                t_reg;
    logic [31:0]                len_reg;
    logic [ats_pkg::PAIR_AW-1:0] pcount_reg;
    logic [NW-1:0]              tsize_reg;
    logic [NW-1:0]              sum_i_reg;
    logic [ats_pkg::MAX_CITIES-1:0] tvalid_reg;
    logic [PW-1:0]              pi_reg, pj_reg;
    logic [PW-1:0]              tv_reg [4];
    logic signed [XW-1:0]       delta_reg;
    logic [32:0]                thr_reg;
    logic [PW-1:0]              lo_reg, hi_reg, lo_val_reg;
    logic                       acc_reg;
    logic [PW-1:0]              fp_reg, lp_reg, city_reg;
    logic                       m_tvalid_reg;
    logic [55:0]                m_tdata_reg;
    logic [PW-1:0]              traddr_q_reg;
    logic                       tvv_reg;

    // Memory and unit hookups.
    logic                           dist_we;
    logic [ats_pkg::DIST_AW-1:0]    dist_waddr, dist_raddr;
    logic [DW-1:0]                  dist_rdata;
    logic                           pair_we;
    ats_pkg::pair_t                 pair_wdata, pair_rdata;
    logic [ats_pkg::PAIR_AW-1:0]    pair_raddr;
    logic                           tour_we;
    logic [PW-1:0]                  tour_waddr, tour_wdata, tour_raddr, tour_rdata;
    logic [PW-1:0]                  tour_rd;
    logic [31:0]                    mul_a, mul_b;
    logic [63:0]                    mul_p;
    logic                           div_start, div_done;
    logic [ats_pkg::PAIR_AW-1:0]    div_rem;

    // Derived values.
    logic [NW-1:0]        eff_n;
    logic [NW-1:0]        sum_nxt;
    logic [NW-1:0]        jn_full;
    logic [PW-1:0]        jn;
    logic [63:0]          draw_val;
    logic [8:0]           exp_ip;
    logic [EB-1:0]        exp_idx;
    logic [32:0]          exp_val;
    logic [32:0]          thr_val;
    logic signed [33:0]   len_sum;
    logic signed [XW-1:0] d_ext;
    logic [1:0]           slot;

    assign in_beat = s_tdata;

    // Effective city count is clamped to the supported range.
    always_comb begin
        if (city_count_reg < NW'(3)) begin
            eff_n = NW'(3);
        end else if (city_count_reg > NW'(ats_pkg::MAX_CITIES)) begin
            eff_n = NW'(ats_pkg::MAX_CITIES);
        end else begin
            eff_n = city_count_reg;
        end
    end

    assign sum_nxt = (sum_i_reg + NW'(1) == tsize_reg) ? '0 : sum_i_reg + NW'(1);
    assign jn_full = ({1'b0, pj_reg} + NW'(1) >= tsize_reg) ? '0 : {1'b0, pj_reg} + NW'(1);
    assign jn      = jn_full[PW-1:0];

    // Entries never written since the last tour start read as their own index.
    assign tour_rd = tvv_reg ? tour_rdata : traddr_q_reg;

    // Last partial product of the generator update closes the high word.
    assign draw_val = {t_reg[63:32] + mul_p[31:0], t_reg[31:0]};

    // y = x*log2(e) in Q.24 sits at product bits 30 and up.
    assign exp_ip  = mul_p[62:54];
    assign exp_idx = mul_p[53 -: EB];
    assign exp_val = ats_pkg::EXP_TAB[exp_idx];
    assign thr_val = (exp_ip[8:5] != 4'd0) ? 33'd0 : exp_val >> exp_ip[4:0];

    assign len_sum = $signed({2'b00, len_reg}) + 34'(delta_reg);
    assign d_ext   = $signed({3'b000, dist_rdata});
    assign slot    = 2'(cnt_reg - 3'd1);

    // Shared multiplier operand select.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_DRAW0: begin
                mul_a = g_reg[31:0];
                mul_b = ats_pkg::LCG_MUL_LO;
            end
            S_DRAW1: begin
                mul_a = g_reg[63:32];
                mul_b = ats_pkg::LCG_MUL_LO;
            end
            S_DRAW2: begin
                mul_a = g_reg[31:0];
                mul_b = ats_pkg::LCG_MUL_HI;
            end
            S_MULX: begin
                mul_a = 32'(delta_reg[XW-2:0]);
                mul_b = invt_reg;
            end
            S_MULY: begin
                mul_a = {2'b00, mul_p[29:0]};
                mul_b = ats_pkg::LOG2E_Q30;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Distance store access: loads, tour sum and the four move distances.
    assign dist_we    = (state_reg == S_LOAD);
    assign dist_waddr = {row_reg, col_reg};
    always_comb begin
        dist_raddr = '0;
        if (state_reg == S_SUMA) begin
            dist_raddr = {sum_i_reg[PW-1:0], sum_nxt[PW-1:0]};
        end else if (state_reg == S_DIST) begin
            case (cnt_reg)
                3'd0:    dist_raddr = {tv_reg[0], tv_reg[1]};
                3'd1:    dist_raddr = {tv_reg[2], tv_reg[3]};
                3'd2:    dist_raddr = {tv_reg[0], tv_reg[2]};
                3'd3:    dist_raddr = {tv_reg[1], tv_reg[3]};
                default: dist_raddr = '0;
            endcase
        end
    end

    assign pair_we          = (state_reg == S_PAIR);
    assign pair_wdata.first = pi_reg;
    assign pair_wdata.last  = pj_reg;
    assign pair_raddr       = div_rem;

    // Tour access: position reads, the four move endpoints, and swaps.
    always_comb begin
        tour_raddr = '0;
        tour_we    = 1'b0;
        tour_waddr = lo_reg;
        tour_wdata = tour_rd;
        unique case (state_reg)
            S_RDPOS: tour_raddr = pos_reg;
            S_TOUR: begin
                case (cnt_reg)
                    3'd0:    tour_raddr = pi_reg - PW'(1);
                    3'd1:    tour_raddr = pi_reg;
                    3'd2:    tour_raddr = pj_reg;
                    3'd3:    tour_raddr = jn;
                    default: tour_raddr = '0;
                endcase
            end
            S_RV0: tour_raddr = lo_reg;
            S_RV1: tour_raddr = hi_reg;
            S_RV2: tour_we = 1'b1;
            S_RV3: begin
                tour_we    = 1'b1;
                tour_waddr = hi_reg;
                tour_wdata = lo_val_reg;
            end
            default: tour_raddr = '0;
        endcase
    end

    assign div_start = (state_reg == S_DRAW3) && !test_reg;

    ats_ram #(.WIDTH(DW), .DEPTH(ats_pkg::MAX_CITIES * ats_pkg::MAX_CITIES)) u_dist_ram (
        .aclk  (aclk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_reg),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    ats_ram #(.WIDTH($bits(ats_pkg::pair_t)), .DEPTH(ats_pkg::PAIR_DEPTH)) u_pair_ram (
        .aclk  (aclk),
        .we    (pair_we),
        .waddr (pcount_reg),
        .wdata (pair_wdata),
        .raddr (pair_raddr),
        .rdata (pair_rdata)
    );

    ats_ram #(.WIDTH(PW), .DEPTH(ats_pkg::MAX_CITIES)) u_tour_ram (
        .aclk  (aclk),
        .we    (tour_we),
        .waddr (tour_waddr),
        .wdata (tour_wdata),
        .raddr (tour_raddr),
        .rdata (tour_rdata)
    );

    ats_mul #(.A_W(32), .B_W(32)) u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    ats_div #(.NUM_W(64), .DEN_W(ats_pkg::PAIR_AW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (draw_val),
        .divisor  (pcount_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    always_comb begin
        out_beat             = '0;
        out_beat.accepted    = acc_reg;
        out_beat.tour_length = len_reg;
        out_beat.first_pos   = fp_reg;
        out_beat.last_pos    = lp_reg;
        out_beat.city        = city_reg;
    end

    // Sequencer: one clocked block for state, control and datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_tvalid_reg   <= 1'b0;
            city_count_reg <= NW'(ats_pkg::MAX_CITIES);
            g_reg          <= 64'd1;
            len_reg        <= '0;
            pcount_reg     <= '0;
            tsize_reg      <= '0;
            tvalid_reg     <= '0;
            test_reg       <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            traddr_q_reg <= tour_raddr;
            tvv_reg      <= tvalid_reg[tour_raddr];
            if (tour_we) begin
                tvalid_reg[tour_waddr] <= 1'b1;
            end

            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        row_reg  <= in_beat.row;
                        col_reg  <= in_beat.col;
                        dist_reg <= in_beat.distance;
                        invt_reg <= in_beat.inverse_temperature;
                        pos_reg  <= in_beat.position;
                        acc_reg  <= 1'b0;
                        fp_reg   <= '0;
                        lp_reg   <= '0;
                        city_reg <= '0;
                        test_reg <= 1'b0;
                        unique case (in_beat.func)
                            ats_pkg::FUNC_LOAD: state_reg <= S_LOAD;
                            ats_pkg::FUNC_READ: state_reg <= S_RDPOS;
                            ats_pkg::FUNC_START: begin
                                tsize_reg  <= eff_n;
                                pcount_reg <= '0;
                                pi_reg     <= PW'(1);
                                pj_reg     <= PW'(2);
                                tvalid_reg <= '0;
                                state_reg  <= S_PAIR;
                            end
                            ats_pkg::FUNC_STEP: begin
                                state_reg <= (pcount_reg == '0) ? S_FIN : S_DRAW0;
                            end
                            default: state_reg <= S_FIN;
                        endcase
                    end
                end
                S_LOAD: state_reg <= S_FIN;
                S_RDPOS: state_reg <= S_CITY;
                S_CITY: begin
                    city_reg  <= tour_rd;
                    state_reg <= S_FIN;
                end
                S_PAIR: begin
                    // Walk pairs (i, j) with 1 <= i < j < n in order.
                    pcount_reg <= pcount_reg + ats_pkg::PAIR_AW'(1);
                    if ({1'b0, pj_reg} + NW'(1) == tsize_reg) begin
                        if ({1'b0, pi_reg} + NW'(2) == tsize_reg) begin
                            sum_i_reg <= '0;
                            len_reg   <= '0;
                            state_reg <= S_SUMA;
                        end else begin
                            pi_reg <= pi_reg + PW'(1);
                            pj_reg <= pi_reg + PW'(2);
                        end
                    end else begin
                        pj_reg <= pj_reg + PW'(1);
                    end
                end
                S_SUMA: state_reg <= S_SUMB;
                S_SUMB: begin
                    len_reg <= len_reg + 32'(dist_rdata);
                    if (sum_i_reg + NW'(1) == tsize_reg) begin
                        state_reg <= S_FIN;
                    end else begin
                        sum_i_reg <= sum_i_reg + NW'(1);
                        state_reg <= S_SUMA;
                    end
                end
                S_DRAW0: state_reg <= S_DRAW1;
                S_DRAW1: begin
                    t_reg     <= mul_p + ats_pkg::LCG_ADD;
                    state_reg <= S_DRAW2;
                end
                S_DRAW2: begin
                    t_reg[63:32] <= t_reg[63:32] + mul_p[31:0];
                    state_reg    <= S_DRAW3;
                end
                S_DRAW3: begin
                    g_reg     <= draw_val;
                    state_reg <= test_reg ? S_CMP : S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        state_reg <= S_PAIRRD;
                    end
                end
                S_PAIRRD: state_reg <= S_PAIRGET;
                S_PAIRGET: begin
                    pi_reg    <= pair_rdata.first;
                    pj_reg    <= pair_rdata.last;
                    fp_reg    <= pair_rdata.first;
                    lp_reg    <= pair_rdata.last;
                    cnt_reg   <= '0;
                    state_reg <= S_TOUR;
                end
                S_TOUR: begin
                    if (cnt_reg != 3'd0) begin
                        tv_reg[slot] <= tour_rd;
                    end
                    if (cnt_reg == 3'd4) begin
                        cnt_reg   <= '0;
                        delta_reg <= '0;
                        state_reg <= S_DIST;
                    end else begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
                S_DIST: begin
                    // Old edges come off, new edges go on.
                    if (cnt_reg == 3'd1 || cnt_reg == 3'd2) begin
                        delta_reg <= delta_reg - d_ext;
                    end else if (cnt_reg != 3'd0) begin
                        delta_reg <= delta_reg + d_ext;
                    end
                    if (cnt_reg == 3'd4) begin
                        state_reg <= S_DEC;
                    end else begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
                S_DEC: state_reg <= delta_reg[XW-1] ? S_ACC : S_MULX;
                S_MULX: state_reg <= S_MULY;
                S_MULY: begin
                    // A scaled change of 2^30 or more is rejected without a draw.
                    state_reg <= (mul_p[63:30] != '0) ? S_FIN : S_MULW;
                end
                S_MULW: begin
                    thr_reg   <= thr_val;
                    test_reg  <= 1'b1;
                    state_reg <= S_DRAW0;
                end
                S_CMP: begin
                    state_reg <= ({1'b0, g_reg[63:32]} < thr_reg) ? S_ACC : S_FIN;
                end
                S_ACC: begin
                    if (len_sum[33]) begin
                        len_reg <= '0;
                    end else if (len_sum[32]) begin
                        len_reg <= 32'hFFFF_FFFF;
                    end else begin
                        len_reg <= len_sum[31:0];
                    end
                    acc_reg   <= 1'b1;
                    lo_reg    <= pi_reg;
                    hi_reg    <= pj_reg;
                    state_reg <= S_RV0;
                end
                S_RV0: state_reg <= S_RV1;
                S_RV1: begin
                    lo_val_reg <= tour_rd;
                    state_reg  <= S_RV2;
                end
                S_RV2: state_reg <= S_RV3;
                S_RV3: begin
                    lo_reg    <= lo_reg + PW'(1);
                    hi_reg    <= hi_reg - PW'(1);
                    state_reg <= (lo_reg + PW'(1) < hi_reg - PW'(1)) ? S_RV0 : S_FIN;
                end
                S_FIN: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= out_beat;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase

            if (cfg_wr_en) begin
                unique case (ats_pkg::cfg_index_t'(cfg_addr))
                    ats_pkg::CFG_CITY_COUNT: city_count_reg <= cfg_wdata[NW-1:0];
                    ats_pkg::CFG_SEED:       g_reg <= cfg_wdata;
                    default:                 g_reg <= g_reg;
                endcase
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A swap only runs on a segment that still has two ends.
    a_swap_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RV0) |-> (lo_reg < hi_reg))
        else $error("segment reversal entered with crossed ends");

    // The drawn pair index stays inside the pair list.
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (div_rem < pcount_reg))
        else $error("pair index out of range");

    // One beat is taken, then the block is busy until it has finished.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second beat taken while busy");

    // A pair list only exists for a latched tour of at least three cities.
    a_pairs_need_tour: assert property (@(posedge aclk) disable iff (!aresetn)
        (pcount_reg != '0 && state_reg == S_IDLE) |-> (tsize_reg >= NW'(3)))
        else $error("pair list without a tour");

endmodule
